FILE: src/swjag_pkg.sv
// shared types, constants and register indexes of the joint angle generator
package swjag_pkg;

   localparam int MAX_JOINTS = 64;
   localparam int IDX_W      = $clog2(MAX_JOINTS);
   localparam int CNT_W      = $clog2(MAX_JOINTS + 1);
   localparam int DIVD_W     = 22;
   localparam int DCNT_W     = 5;

   localparam logic [15:0] TAPER_BASE  = 16'd6554;
   localparam logic [15:0] TAPER_SPAN  = 16'd58982;
   localparam logic [15:0] SIN_C1      = 16'd25736;
   localparam logic [15:0] SIN_C2      = 16'd10512;
   localparam logic [15:0] SIN_C3      = 16'd1160;
   localparam logic [15:0] QUARTER     = 16'h4000;

   localparam logic [2:0] REG_OFFSET_EVEN = 3'd0;
   localparam logic [2:0] REG_OFFSET_ODD  = 3'd1;
   localparam logic [2:0] REG_AMP_EVEN    = 3'd2;
   localparam logic [2:0] REG_AMP_ODD     = 3'd3;
   localparam logic [2:0] REG_STEPS       = 3'd4;
   localparam logic [2:0] REG_RATE_EVEN   = 3'd5;
   localparam logic [2:0] REG_RATE_ODD    = 3'd6;
   localparam logic [2:0] REG_PHASE_SHIFT = 3'd7;

   typedef struct packed {
      logic load;
      logic adv;
      logic jstart;
      logic div_step;
      logic sx2;
      logic st1;
      logic st2;
      logic ss;
      logic ma;
      logic mb;
      logic fin;
      logic next;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic last;
   } status_type;

endpackage

FILE: src/sidewinding_joint_angle_generator.sv
// top level of the sidewinding joint angle generator
//
//  channel  dir  payload
//  req      in   tdata: step_time[15:0], joint_count[22:16]
//  rsp      out  tdata: joint_index[5:0], joint_angle[21:6]; tlast: last_joint
//  csr      in   write enable, 3-bit index, 32-bit data
//
// a tick first updates the phases, then handles each joint in turn: start,
// the 22-step taper divider, sine and scaling, then the wait for rsp_tready
// reset clears phases, registers to defaults and the controller to idle
// one tick at a time; req_tready is low until the last joint is taken
module sidewinding_joint_angle_generator import swjag_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // step_time, joint_count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // joint_index, joint_angle
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] joint_index;
   logic [15:0]      joint_angle;

   swjag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swjag_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .step_time   (req_tdata[15:0]),
      .joint_count (req_tdata[22:16]),
      .cmd         (cmd),
      .status      (status),
      .joint_index (joint_index),
      .joint_angle (joint_angle),
      .last_joint  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, joint_angle, joint_index};

endmodule

FILE: src/swjag_ctrl.sv
// controller state machine sequencing ticks and joints
module swjag_ctrl import swjag_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE = 12'b000000000001,
      ST_ADV  = 12'b000000000010,
      ST_JST  = 12'b000000000100,
      ST_DIV  = 12'b000000001000,
      ST_SX2  = 12'b000000010000,
      ST_ST1  = 12'b000000100000,
      ST_ST2  = 12'b000001000000,
      ST_SS   = 12'b000010000000,
      ST_MA   = 12'b000100000000,
      ST_MB   = 12'b001000000000,
      ST_FIN  = 12'b010000000000,
      ST_OUT  = 12'b100000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.adv = 1'b1;
            if (status.n_zero) state_in = ST_IDLE;
            else state_in = ST_JST;
         end
         ST_JST: begin
            cmd.jstart = 1'b1;
            cnt_in     = DCNT_W'(DIVD_W - 1);
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_SX2;
         end
         ST_SX2: begin
            cmd.sx2  = 1'b1;
            state_in = ST_ST1;
         end
         ST_ST1: begin
            cmd.st1  = 1'b1;
            state_in = ST_ST2;
         end
         ST_ST2: begin
            cmd.st2  = 1'b1;
            state_in = ST_SS;
         end
         ST_SS: begin
            cmd.ss   = 1'b1;
            state_in = ST_MA;
         end
         ST_MA: begin
            cmd.ma   = 1'b1;
            state_in = ST_MB;
         end
         ST_MB: begin
            cmd.mb   = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (status.last) state_in = ST_IDLE;
               else begin
                  cmd.next = 1'b1;
                  state_in = ST_JST;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: src/swjag_dp.sv
// datapath: registers, phase accumulators, divider, sine and scaling
module swjag_dp import swjag_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   input  logic [15:0]      step_time,
   input  logic [6:0]       joint_count,
   input  cmd_type          cmd,
   output status_type       status,
   output logic [IDX_W-1:0] joint_index,
   output logic [15:0]      joint_angle,
   output logic             last_joint
);

   logic [15:0] offset_even_ff, offset_odd_ff, rho_ff;
   logic [14:0] amp_even_ff, amp_odd_ff;
   logic [31:0] steps_ff;
   logic [23:0] rate_even_ff, rate_odd_ff;
   logic [31:0] phase_even_ff, phase_odd_ff;

   logic [15:0]       dt_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [15:0]       p_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DIVD_W-1:0] dvd_ff;
   logic [14:0]       x_ff, x2_ff;
   logic [1:0]        q_ff;
   logic [13:0]       t1_ff;
   logic [15:0]       t2_ff, s_ff;
   logic [16:0]       taper_ff;
   logic [30:0]       pa_ff;
   logic [17:0]       mag_ff;
   logic [IDX_W-1:0]  out_idx_ff;
   logic [15:0]       out_angle_ff;
   logic              out_last_ff;

   logic              odd;
   logic [CNT_W-1:0]  idx_p1;
   logic [15:0]       term, p_in;
   logic [CNT_W:0]    rem_sh;
   logic [15:0]       x_raw;
   logic [29:0]       xx;
   logic [29:0]       c3x2;
   logic [28:0]       x2t1;
   logic [30:0]       xt2;
   logic [47:0]       prod;
   logic signed [18:0] sum;
   logic [CNT_W-1:0]  n_clip;

   assign odd    = idx_ff[0];
   assign idx_p1 = CNT_W'(idx_ff) + 1'b1;
   assign n_clip = (joint_count > 7'(MAX_JOINTS)) ? CNT_W'(MAX_JOINTS) : CNT_W'(joint_count);

   always_comb begin
      if (odd) begin
         term = 16'(idx_ff * steps_ff[31:16]) + rho_ff + QUARTER;
         p_in = phase_odd_ff[31:16] + term;
      end else begin
         term = 16'(idx_ff * steps_ff[15:0]);
         p_in = phase_even_ff[31:16] + term;
      end
   end

   assign rem_sh = {rem_ff, dvd_ff[DIVD_W-1]};
   assign x_raw  = p_ff[14] ? (QUARTER - {2'b00, p_ff[13:0]}) : {2'b00, p_ff[13:0]};
   assign xx     = x_ff * x_ff;
   assign c3x2   = 30'(SIN_C3) * 30'(x2_ff);
   assign x2t1   = x2_ff * t1_ff;
   assign xt2    = x_ff * t2_ff;
   assign prod   = 48'(pa_ff) * 48'(taper_ff) + 48'h0000_2000_0000;

   always_comb begin
      logic signed [18:0] off;
      logic signed [18:0] m;
      off = odd ? 19'(signed'(offset_odd_ff)) : 19'(signed'(offset_even_ff));
      m   = signed'({1'b0, mag_ff});
      sum = q_ff[1] ? (off - m) : (off + m);
   end

   assign status      = {(n_ff == '0), out_last_ff};
   assign joint_index = out_idx_ff;
   assign joint_angle = out_angle_ff;
   assign last_joint  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_even_ff <= '0;
         offset_odd_ff  <= '0;
         amp_even_ff    <= 15'd11438;
         amp_odd_ff     <= 15'd11438;
         steps_ff       <= 32'h5555_5555;
         rate_even_ff   <= 24'd41722;
         rate_odd_ff    <= 24'd41722;
         rho_ff         <= 16'd8192;
         phase_even_ff  <= '0;
         phase_odd_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_OFFSET_EVEN: offset_even_ff <= csr_wdata[15:0];
               REG_OFFSET_ODD:  offset_odd_ff  <= csr_wdata[15:0];
               REG_AMP_EVEN:    amp_even_ff    <= csr_wdata[14:0];
               REG_AMP_ODD:     amp_odd_ff     <= csr_wdata[14:0];
               REG_STEPS:       steps_ff       <= csr_wdata;
               REG_RATE_EVEN:   rate_even_ff   <= csr_wdata[23:0];
               REG_RATE_ODD:    rate_odd_ff    <= csr_wdata[23:0];
               REG_PHASE_SHIFT: rho_ff         <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.adv) begin
            phase_even_ff <= phase_even_ff + 32'(rate_even_ff * dt_ff);
            phase_odd_ff  <= phase_odd_ff + 32'(rate_odd_ff * dt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dt_ff  <= step_time;
         n_ff   <= n_clip;
         idx_ff <= '0;
      end
      if (cmd.next) idx_ff <= idx_ff + 1'b1;
      if (cmd.jstart) begin
         p_ff   <= p_in;
         rem_ff <= '0;
         dvd_ff <= DIVD_W'(TAPER_SPAN * idx_p1);
      end
      if (cmd.div_step) begin
         x_ff <= x_raw[14:0];
         q_ff <= p_ff[15:14];
         if (rem_sh >= {1'b0, n_ff}) begin
            rem_ff <= CNT_W'(rem_sh - {1'b0, n_ff});
            dvd_ff <= {dvd_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[CNT_W-1:0];
            dvd_ff <= {dvd_ff[DIVD_W-2:0], 1'b0};
         end
      end
      if (cmd.sx2) begin
         x2_ff    <= xx[28:14];
         taper_ff <= 17'(TAPER_BASE) + 17'(dvd_ff);
      end
      if (cmd.st1) t1_ff <= 14'(SIN_C2 - 16'(c3x2[29:14]));
      if (cmd.st2) t2_ff <= SIN_C1 - 16'(x2t1[28:14]);
      if (cmd.ss)  s_ff  <= xt2[29:14];
      if (cmd.ma)  pa_ff <= (odd ? amp_odd_ff : amp_even_ff) * s_ff;
      if (cmd.mb)  mag_ff <= prod[47:30];
      if (cmd.fin) begin
         out_idx_ff <= idx_ff;
         out_last_ff <= (idx_p1 == n_ff);
         if (sum > 19'sd32767) out_angle_ff <= 16'h7FFF;
         else if (sum < -19'sd32768) out_angle_ff <= 16'h8000;
         else out_angle_ff <= sum[15:0];
      end
   end

endmodule

FILE: tb/tb_sidewinding_joint_angle_generator.sv
// testbench of the sidewinding joint angle generator: directed and random ticks, scoreboard
module tb_sidewinding_joint_angle_generator import swjag_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]  idx;
      logic [15:0] angle;
      logic        last;
   } joint_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // step_time[15:0], joint_count[22:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // joint_index[5:0], joint_angle[21:6]
   logic        rsp_tlast;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   logic [15:0] m_off_even, m_off_odd, m_rho;
   logic [14:0] m_amp_even, m_amp_odd;
   logic [31:0] m_steps, m_phase_even, m_phase_odd;
   logic [23:0] m_rate_even, m_rate_odd;

   joint_result_type angle_queue[$];
   int  errors;
   int  idle_cycles;
   bit  hold_off;
   int  hold_count;

   sidewinding_joint_angle_generator u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [16:0] wave_sine(logic [31:0] ph);
      logic [15:0] p;
      logic [31:0] x, x2, t1, t2, s;
      p = ph[31:16];
      x = {18'd0, p[13:0]};
      if (p[14]) x = 32'd16384 - x;
      x2 = (x * x) >> 14;
      t1 = 32'd10512 - ((32'd1160 * x2) >> 14);
      t2 = 32'd25736 - ((x2 * t1) >> 14);
      s = (x * t2) >> 14;
      return p[15] ? -$signed({1'b0, s[15:0]}) : $signed({1'b0, s[15:0]});
   endfunction

   function automatic logic [15:0] joint_angle(int i, int n, logic [31:0] ph,
                                               logic [14:0] amp, logic [15:0] off);
      logic signed [16:0] s;
      longint mag_s, taper, prod, v;
      s = wave_sine(ph);
      mag_s = (s < 0) ? -s : s;
      taper = 6554 + (58982 * (i + 1)) / n;
      prod = longint'(amp) * mag_s * taper + (64'd1 << 29);
      v = longint'($signed(off)) + ((s < 0) ? -(prod >>> 30) : (prod >>> 30));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   task automatic predict_tick(logic [15:0] dt, logic [6:0] cnt);
      int n;
      logic [31:0] ph;
      joint_result_type r;
      m_phase_even += m_rate_even * dt;
      m_phase_odd  += m_rate_odd * dt;
      n = (cnt > MAX_JOINTS) ? MAX_JOINTS : cnt;
      for (int i = 0; i < n; i++) begin
         if (i % 2 == 0) begin
            ph = m_phase_even + {16'(i * m_steps[15:0]), 16'd0};
            r.angle = joint_angle(i, n, ph, m_amp_even, m_off_even);
         end else begin
            ph = m_phase_odd + {16'(i * m_steps[31:16] + m_rho), 16'd0} + 32'h4000_0000;
            r.angle = joint_angle(i, n, ph, m_amp_odd, m_off_odd);
         end
         r.idx = i[5:0];
         r.last = (i + 1 == n);
         angle_queue = {angle_queue, r};
      end
   endtask

   task automatic send_tick(logic [15:0] dt, logic [6:0] cnt);
      int g;
      g = gap_len();
      repeat (g + 1) @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, cnt, dt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tick(dt, cnt);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_OFFSET_EVEN: m_off_even = val[15:0];
         REG_OFFSET_ODD:  m_off_odd = val[15:0];
         REG_AMP_EVEN:    m_amp_even = val[14:0];
         REG_AMP_ODD:     m_amp_odd = val[14:0];
         REG_STEPS:       m_steps = val;
         REG_RATE_EVEN:   m_rate_even = val[23:0];
         REG_RATE_ODD:    m_rate_odd = val[23:0];
         default:         m_rho = val[15:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drain();
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_tick(int max_n);
      send_tick(16'($urandom), 7'($urandom_range(0, max_n)));
   endtask

   task automatic test_defaults();
      send_tick(16'd0, 7'd1);
      send_tick(16'hffff, 7'd64);
      send_tick(16'd1, 7'd0);
      send_tick(16'h8000, 7'd127);
      send_tick(16'h5555, 7'd65);
      send_tick(16'haaaa, 7'd2);
      send_tick(16'd300, 7'd3);
      wait_drain();
   endtask

   task automatic test_extreme_regs();
      write_reg(REG_OFFSET_EVEN, 32'h0000_7fff);
      write_reg(REG_OFFSET_ODD, 32'h0000_8000);
      write_reg(REG_AMP_EVEN, 32'h0000_7fff);
      write_reg(REG_AMP_ODD, 32'h0000_7fff);
      write_reg(REG_STEPS, 32'hffff_ffff);
      write_reg(REG_RATE_EVEN, 32'h00ff_ffff);
      write_reg(REG_RATE_ODD, 32'h00ff_ffff);
      write_reg(REG_PHASE_SHIFT, 32'h0000_ffff);
      send_tick(16'hffff, 7'd64);
      send_tick(16'h1234, 7'd5);
      send_tick(16'd0, 7'd1);
      wait_drain();
      write_reg(REG_OFFSET_EVEN, 32'h0000_8000);
      write_reg(REG_OFFSET_ODD, 32'h0000_7fff);
      write_reg(REG_AMP_EVEN, 32'd0);
      write_reg(REG_AMP_ODD, 32'd0);
      write_reg(REG_STEPS, 32'd0);
      write_reg(REG_RATE_EVEN, 32'd0);
      write_reg(REG_RATE_ODD, 32'd0);
      write_reg(REG_PHASE_SHIFT, 32'd0);
      send_tick(16'hffff, 7'd64);
      send_tick(16'd7, 7'd9);
      wait_drain();
   endtask

   task automatic test_backpressure();
      hold_count = 400;
      hold_off = 1'b1;
      for (int k = 0; k < 4; k++) random_tick(8);
      wait_drain();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         for (int r = 0; r < 8; r++) write_reg(3'(r), $urandom);
         for (int k = 0; k < 44; k++) random_tick(($urandom_range(0, 9) == 0) ? 127 : 12);
         wait_drain();
      end
   endtask

   // result checker
   always @(posedge clock) begin
      joint_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.idx = rsp_tdata[5:0];
         got.angle = rsp_tdata[21:6];
         got.last = rsp_tlast;
         if (angle_queue.size() == 0) begin
            $display("%0t unexpected item: actual %h", $realtime, got);
            errors++;
         end else begin
            want = angle_queue.pop_front();
            if (got.idx !== want.idx || got.angle !== want.angle || got.last !== want.last
                || rsp_tdata[23:22] !== 2'b00) begin
               $display("%0t mismatch: expected idx %0d angle %h last %b, actual idx %0d angle %h last %b",
                        $realtime, want.idx, want.angle, want.last, got.idx, got.angle, got.last);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
         if (hold_count > 0) hold_count--;
         else hold_off = 1'b0;
      end else begin
         rsp_tready <= (gap_len() == 0) || ($urandom_range(0, 2) == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles > 20000) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      errors = 0;
      idle_cycles = 0;
      hold_off = 1'b0;
      hold_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      m_off_even = 0; m_off_odd = 0;
      m_amp_even = 15'd11438; m_amp_odd = 15'd11438;
      m_steps = 32'd1431655765;
      m_rate_even = 24'd41722; m_rate_odd = 24'd41722;
      m_rho = 16'd8192;
      m_phase_even = 0; m_phase_odd = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_defaults();
      test_extreme_regs();
      test_backpressure();
      test_random_settings();
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
